FILE: rtl/core/mhht_pkg.sv
`default_nettype none

package mhht_pkg;

  localparam int KEY_W = 16;
  localparam int HID_W = 8;
  localparam int REM_STEPS = 3;
  localparam int REM_CW = $clog2(REM_STEPS);

  localparam logic [1:0] MODE_INSERT   = 2'd0;
  localparam logic [1:0] MODE_DISPATCH = 2'd1;
  localparam logic [1:0] MODE_QUERY    = 2'd2;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TABLE_FULL = 2'd1,
    ST_LIST_FULL  = 2'd2,
    ST_NOT_FOUND  = 2'd3
  } mhht_status_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
    logic [HID_W-1:0] handler_id;
  } mhht_in_t;

  typedef struct packed {
    mhht_status_t     status;
    logic [HID_W-1:0] handler_out;
    logic             has_handler;
    logic             last;
  } mhht_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HOME,
    S_PRB_RD,
    S_PRB_CHK,
    S_HRD,
    S_HLD,
    S_EMIT
  } mhht_state_t;

  typedef struct packed {
    logic         load;
    logic         rem_step;
    logic         probe_next;
    logic         claim;
    logic         append;
    logic         hrd_next;
    logic         res_load;
    logic         res_from_store;
    mhht_status_t res_status;
    logic         res_has;
    logic         res_last;
  } mhht_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       rem_done;
    logic       slot_valid;
    logic       key_match;
    logic       probe_last;
    logic       table_room;
    logic       cnt_full;
    logic       cnt_zero;
    logic       hrd_last;
    logic       out_last;
  } mhht_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/message_handler_hash_table_top.sv
`default_nettype none

// Message handler table: open-addressed hash of 16-bit keys onto SLOT_COUNT
// slots (home = key mod SLOT_COUNT, linear probe with wrap), each slot holding
// up to HANDLERS_PER_SLOT handler ids. One item at a time: in_ready is high
// only while idle. After the idle cycle that accepts the item, the reciprocal
// remainder steps (quotient estimate, back-multiply, fix-up) find the home slot
// and each probe, up to SLOT_COUNT, reads the registered key memory and then
// checks the stored key. Insert and query present their single result in the
// cycle after the final probe check; a dispatch emits one result per handler
// (a single not-found result if there is none), each read from the handler
// memory through its read register. Results wait in an output register until
// out_ready, which stalls the item; last marks the final result of an item.

module message_handler_hash_table_top #(
  parameter int SLOT_COUNT = 16,
  parameter int HANDLERS_PER_SLOT = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mhht_pkg::mhht_in_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mhht_pkg::mhht_out_t      out_data
);
  import mhht_pkg::*;

  mhht_cmd_t cmd;
  mhht_sts_t sts;

  mhht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mhht_dp #(
    .SLOT_COUNT        (SLOT_COUNT),
    .HANDLERS_PER_SLOT (HANDLERS_PER_SLOT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/core/mhht_dp.sv
`default_nettype none

module mhht_dp #(
  parameter int SLOT_COUNT = 16,
  parameter int HANDLERS_PER_SLOT = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mhht_pkg::mhht_in_t  in_data,
  input  wire mhht_pkg::mhht_cmd_t cmd,
  output mhht_pkg::mhht_sts_t      sts,
  output mhht_pkg::mhht_out_t      out_data
);
  import mhht_pkg::*;

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(HANDLERS_PER_SLOT + 1);
  localparam int HW = (HANDLERS_PER_SLOT > 1) ? $clog2(HANDLERS_PER_SLOT) : 1;
  localparam int AW = $clog2(SLOT_COUNT * HANDLERS_PER_SLOT);
  localparam int UW = $clog2(SLOT_COUNT + 1);
  localparam int DEPTH = SLOT_COUNT * HANDLERS_PER_SLOT;
  localparam int PW = KEY_W + 32;

  localparam logic [31:0]      RECIP    = 32'((64'd1 << 32) / SLOT_COUNT);
  localparam logic [KEY_W-1:0] SC_K     = KEY_W'(SLOT_COUNT);
  localparam logic [SW-1:0]    SLOT_MAX = SW'(SLOT_COUNT - 1);
  localparam logic [CW-1:0]    CNT_MAX  = CW'(HANDLERS_PER_SLOT);
  localparam logic [AW-1:0]    HPS      = AW'(HANDLERS_PER_SLOT);
  localparam logic [UW-1:0]    USED_MAX = UW'(SLOT_COUNT);

  logic [1:0]        mode_r;
  logic [KEY_W-1:0]  key_r;
  logic [KEY_W-1:0]  q_r;
  logic [KEY_W-1:0]  r_r;
  logic [HID_W-1:0]  hid_r;
  logic [REM_CW-1:0] rem_cnt_r;
  logic [SW-1:0]     idx_r;
  logic [SW-1:0]     n_r;
  logic [HW-1:0]     h_r;
  logic [UW-1:0]     used_r;
  logic              valid_r [SLOT_COUNT];
  logic [CW-1:0]     cnt_r [SLOT_COUNT];
  logic [KEY_W-1:0]  key_mem [SLOT_COUNT];
  logic [HID_W-1:0]  hnd_mem [DEPTH];
  logic [KEY_W-1:0]  key_rd_r;
  logic [HID_W-1:0]  hd_rd_r;
  mhht_out_t         out_r;

  logic [PW-1:0]    qprod;
  logic [KEY_W-1:0] qsc;
  logic [KEY_W-1:0] r_fix;
  logic [SW-1:0]    rem_nxt;
  logic [CW-1:0]    cnt_cur;
  logic [AW-1:0]    base;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;

  // home slot: reciprocal estimate of the quotient, back-multiply, one fix-up
  always_comb begin
    qprod   = PW'(key_r) * PW'(RECIP);
    qsc     = q_r * SC_K;
    r_fix   = (r_r >= SC_K) ? r_r - SC_K : r_r;
    rem_nxt = r_fix[SW-1:0];
  end

  assign cnt_cur = cnt_r[idx_r];
  assign base    = AW'(idx_r) * HPS;
  assign wr_addr = cmd.claim ? base : base + AW'(cnt_cur);
  assign rd_addr = base + AW'(h_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= in_data.mode;
      key_r     <= in_data.key;
      hid_r     <= in_data.handler_id;
      rem_cnt_r <= '0;
      idx_r     <= '0;
      n_r       <= '0;
      h_r       <= '0;
    end else begin
      if (cmd.rem_step) begin
        q_r       <= qprod[PW-1:32];
        r_r       <= key_r - qsc;
        idx_r     <= rem_nxt;
        rem_cnt_r <= rem_cnt_r + REM_CW'(1);
      end
      if (cmd.probe_next) begin
        idx_r <= (idx_r == SLOT_MAX) ? '0 : idx_r + SW'(1);
        n_r   <= n_r + SW'(1);
      end
      if (cmd.hrd_next) begin
        h_r <= h_r + HW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        valid_r[i] <= 1'b0;
        cnt_r[i]   <= '0;
      end
    end else if (cmd.claim) begin
      used_r         <= used_r + UW'(1);
      valid_r[idx_r] <= 1'b1;
      cnt_r[idx_r]   <= CW'(1);
    end else if (cmd.append) begin
      cnt_r[idx_r] <= cnt_cur + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.claim) begin
      key_mem[idx_r] <= key_r;
    end
    key_rd_r <= key_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.claim || cmd.append) begin
      hnd_mem[wr_addr] <= hid_r;
    end
    hd_rd_r <= hnd_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_r.status      <= cmd.res_status;
      out_r.handler_out <= cmd.res_from_store ? hd_rd_r : '0;
      out_r.has_handler <= cmd.res_has;
      out_r.last        <= cmd.res_last;
    end
  end

  assign out_data = out_r;

  always_comb begin
    sts.mode       = mode_r;
    sts.rem_done   = (rem_cnt_r == REM_CW'(REM_STEPS - 1));
    sts.slot_valid = valid_r[idx_r];
    sts.key_match  = (key_rd_r == key_r);
    sts.probe_last = (n_r == SLOT_MAX);
    sts.table_room = (used_r < USED_MAX);
    sts.cnt_full   = (cnt_cur >= CNT_MAX);
    sts.cnt_zero   = (cnt_cur == '0);
    sts.hrd_last   = (CW'(h_r) + CW'(1) >= cnt_cur);
    sts.out_last   = out_r.last;
  end

endmodule

`default_nettype wire

FILE: rtl/core/mhht_ctrl.sv
`default_nettype none

module mhht_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire mhht_pkg::mhht_sts_t sts,
  output mhht_pkg::mhht_cmd_t      cmd
);
  import mhht_pkg::*;

  mhht_state_t state_r;
  mhht_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_status = ST_OK;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_HOME;
        end
      end
      S_HOME: begin
        cmd.rem_step = 1'b1;
        if (sts.rem_done) begin
          state_nxt = S_PRB_RD;
        end
      end
      S_PRB_RD: begin
        state_nxt = S_PRB_CHK;
      end
      S_PRB_CHK: begin
        cmd.res_last = 1'b1;
        if (!sts.slot_valid || (!sts.key_match && sts.probe_last)) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          state_nxt      = S_EMIT;
          if (sts.mode == MODE_INSERT) begin
            if (sts.slot_valid || !sts.table_room) begin
              cmd.res_status = ST_TABLE_FULL;
            end else begin
              cmd.claim      = 1'b1;
              cmd.res_status = ST_OK;
              cmd.res_has    = 1'b1;
            end
          end
        end else if (sts.key_match) begin
          case (sts.mode)
            MODE_INSERT: begin
              cmd.res_load = 1'b1;
              cmd.res_has  = 1'b1;
              state_nxt    = S_EMIT;
              if (sts.cnt_full) begin
                cmd.res_status = ST_LIST_FULL;
              end else begin
                cmd.append = 1'b1;
              end
            end
            MODE_DISPATCH: begin
              if (sts.cnt_zero) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_NOT_FOUND;
                state_nxt      = S_EMIT;
              end else begin
                state_nxt = S_HRD;
              end
            end
            default: begin
              cmd.res_load = 1'b1;
              state_nxt    = S_EMIT;
              if (sts.cnt_zero) begin
                cmd.res_status = ST_NOT_FOUND;
              end else begin
                cmd.res_has = 1'b1;
              end
            end
          endcase
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = S_PRB_RD;
        end
      end
      S_HRD: begin
        state_nxt = S_HLD;
      end
      S_HLD: begin
        cmd.res_load       = 1'b1;
        cmd.res_from_store = 1'b1;
        cmd.res_has        = 1'b1;
        cmd.res_last       = sts.hrd_last;
        state_nxt          = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.out_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.hrd_next = 1'b1;
            state_nxt    = S_HRD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while an item is pending");

  a_claim_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.claim |-> (sts.table_room && !sts.slot_valid))
    else $error("slot claimed without room");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> (!sts.cnt_full && sts.key_match))
    else $error("append into full list");

  a_res_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> out_valid)
    else $error("loaded result not presented");

endmodule

`default_nettype wire
